>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file nrmc_checker.sv.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/nrmc_pkg.sv
package nrmc_pkg;

	// Number format: integer part saturates at 99999, six fraction places are kept.
	localparam int FRAC_DIGITS = 6;
	localparam int INT_W       = 17;
	localparam int FRAC_W      = 20;
	localparam int FPOS_W      = 3;
	localparam logic [INT_W-1:0] INT_LIMIT = 17'd99999;

	// Widths inside the conversion pipeline.
	localparam int DEG_W    = 10;
	localparam int MIN_W    = 7;
	localparam int MINF_W   = 27;
	localparam int QUOT_W   = 24;
	localparam int DEGSC_W  = 34;
	localparam int LAT_W    = 35;
	localparam int SPD_W    = 28;
	localparam int SPDMAG_W = 27;
	localparam int MILLI_W  = 10;

	// Reciprocal multipliers: x / 100, x / 3 and x / 1000 for the value ranges used here.
	localparam int P100_W     = 35;
	localparam int DIV100_SH  = 24;
	localparam logic [17:0] DIV100_MUL = 18'd167773;
	localparam int P3_W       = 52;
	localparam int DIV3_SH    = 27;
	localparam logic [25:0] DIV3_MUL = 26'd44739243;
	localparam int P1000_W    = 41;
	localparam int DIV1000_SH = 30;
	localparam logic [20:0] DIV1000_MUL = 21'd1073742;

	localparam logic [INT_W-1:0]    HUNDRED    = 17'd100;
	localparam logic [MINF_W-1:0]   FRAC_SCALE = 27'd1000000;
	localparam logic [DEGSC_W-1:0]  DEG_SCALE  = 34'd10000000;
	localparam logic [SPDMAG_W-1:0] THOUSAND   = 27'd1000;
	localparam logic signed [SPD_W-1:0] SPEED_LIMIT = 28'sd99999999;

	// Characters of interest.
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_R     = "R";
	localparam logic [7:0] CH_M     = "M";
	localparam logic [7:0] CH_C     = "C";
	localparam logic [7:0] CH_A     = "A";
	localparam logic [7:0] CH_S     = "S";
	localparam logic [7:0] CH_W     = "W";
	localparam logic [7:0] CH_STAR  = "*";
	localparam logic [7:0] CH_COMMA = ",";
	localparam logic [7:0] CH_DOT   = ".";
	localparam logic [7:0] CH_MINUS = "-";
	localparam logic [7:0] CH_0     = "0";
	localparam logic [7:0] CH_9     = "9";

	// Field numbers of the RMC sentence counted from the address field.
	localparam logic [3:0] FIELD_STATUS = 4'd2;
	localparam logic [3:0] FIELD_LAT    = 4'd3;
	localparam logic [3:0] FIELD_NS     = 4'd4;
	localparam logic [3:0] FIELD_LON    = 4'd5;
	localparam logic [3:0] FIELD_EW     = 4'd6;
	localparam logic [3:0] FIELD_SPEED  = 4'd7;
	localparam logic [3:0] FIELD_COURSE = 4'd8;
	localparam logic [3:0] FIELD_LAST   = 4'd15;

	// A parsed number: sign, integer part and fraction scaled to FRAC_DIGITS places.
	typedef struct packed {
		logic              neg;
		logic [INT_W-1:0]  ipart;
		logic [FRAC_W-1:0] fpart;
	} raw_val_t;

	// Everything one sentence yields before unit conversion.
	typedef struct packed {
		logic     found;
		logic     fix;
		raw_val_t lat;
		raw_val_t lon;
		raw_val_t spd;
		raw_val_t crs;
	} raw_res_t;

	// Weight of a fraction digit at a given place after the point.
	function automatic logic [FRAC_W-1:0] frac_weight(input logic [FPOS_W-1:0] pos);
		logic [FRAC_W-1:0] w;
		unique case (pos)
			3'd0: w = 20'd100000;
			3'd1: w = 20'd10000;
			3'd2: w = 20'd1000;
			3'd3: w = 20'd100;
			3'd4: w = 20'd10;
			3'd5: w = 20'd1;
			default: w = '0;
		endcase
		return w;
	endfunction

endpackage

>>> rtl/core/nrmc_parser.sv
module nrmc_parser #(
	parameter int FIELD_BUFFER_BYTES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [7:0]         char_byte,
	input  logic               sentence_end,
	output nrmc_pkg::raw_res_t res
);

	localparam int CLEN_W  = $clog2(FIELD_BUFFER_BYTES);
	localparam logic [CLEN_W:0] CHUNK_MAX = (CLEN_W+1)'(FIELD_BUFFER_BYTES - 1);
	localparam int IWIDE_W = nrmc_pkg::INT_W + 3;
	localparam logic [nrmc_pkg::FPOS_W-1:0] FPOS_LIMIT =
		nrmc_pkg::FPOS_W'(nrmc_pkg::FRAC_DIGITS);

	typedef struct packed {
		logic [1:0]                    match;
		logic                          found;
		logic                          stop;
		logic                          ended;
		logic [3:0]                    field;
		logic [CLEN_W-1:0]             clen;
		logic [7:0]                    cfirst;
		logic                          cneg;
		logic                          point;
		logic [nrmc_pkg::INT_W-1:0]    iacc;
		logic [nrmc_pkg::FRAC_W-1:0]   facc;
		logic [nrmc_pkg::FPOS_W-1:0]   fpos;
		logic                          status;
		logic                          south;
		logic                          west;
		nrmc_pkg::raw_val_t            lat;
		nrmc_pkg::raw_val_t            lon;
		nrmc_pkg::raw_val_t            spd;
		nrmc_pkg::raw_val_t            crs;
	} pstate_t;

	pstate_t                     st_q;
	pstate_t                     st_d;
	logic [7:0]                  match_char;
	logic                        is_digit;
	logic [3:0]                  digit;
	logic [IWIDE_W-1:0]          iwide;
	logic [nrmc_pkg::FRAC_W-1:0] fadd;
	logic [CLEN_W:0]             clen_inc;
	logic                        first;
	logic                        commit;
	logic                        lat_nz;
	logic                        lon_nz;

	// Digit value, next integer part and next fraction contribution.
	assign is_digit = (char_byte >= nrmc_pkg::CH_0) && (char_byte <= nrmc_pkg::CH_9);
	assign digit    = char_byte[3:0];
	assign iwide    = IWIDE_W'(st_q.iacc) * IWIDE_W'(10) + IWIDE_W'(digit);
	assign fadd     = is_digit ? nrmc_pkg::FRAC_W'(digit) * nrmc_pkg::frac_weight(st_q.fpos) : '0;
	assign clen_inc = {1'b0, st_q.clen} + (CLEN_W+1)'(1);
	assign first    = (st_q.clen == '0);

	// Letter expected next while searching for the sentence name.
	always_comb begin
		unique case (st_q.match)
			2'd1:    match_char = nrmc_pkg::CH_M;
			2'd2:    match_char = nrmc_pkg::CH_C;
			default: match_char = nrmc_pkg::CH_R;
		endcase
	end

	// Next parse state for the word in the input register.
	always_comb begin
		st_d   = st_q;
		commit = 1'b0;
		if (!st_q.ended) begin
			if (char_byte == nrmc_pkg::CH_NUL) begin
				commit   = st_q.found && !st_q.stop;
				st_d.ended = 1'b1;
			end else if (!st_q.found) begin
				if (char_byte == match_char) begin
					if (st_q.match == 2'd2) begin
						st_d.found = 1'b1;
						st_d.match = 2'd0;
					end else begin
						st_d.match = st_q.match + 2'd1;
					end
				end else begin
					st_d.match = (char_byte == nrmc_pkg::CH_R) ? 2'd1 : 2'd0;
				end
			end else if (!st_q.stop) begin
				if (char_byte == nrmc_pkg::CH_COMMA) begin
					commit = 1'b1;
					if (st_q.field != nrmc_pkg::FIELD_LAST) begin
						st_d.field = st_q.field + 4'd1;
					end
				end else if (char_byte == nrmc_pkg::CH_STAR) begin
					commit    = 1'b1;
					st_d.stop = 1'b1;
				end else begin
					// Data character: a leading minus sets the sign, a point starts the fraction.
					if (first) begin
						st_d.cfirst = char_byte;
						if (char_byte == nrmc_pkg::CH_MINUS) begin
							st_d.cneg = 1'b1;
						end
					end
					if (!(first && char_byte == nrmc_pkg::CH_MINUS)) begin
						if (char_byte == nrmc_pkg::CH_DOT) begin
							st_d.point = 1'b1;
						end else if (st_q.point) begin
							if (st_q.fpos < FPOS_LIMIT) begin
								st_d.facc = st_q.facc + fadd;
								st_d.fpos = st_q.fpos + nrmc_pkg::FPOS_W'(1);
							end
						end else if (is_digit) begin
							st_d.iacc = (iwide > IWIDE_W'(nrmc_pkg::INT_LIMIT)) ?
								nrmc_pkg::INT_LIMIT : iwide[nrmc_pkg::INT_W-1:0];
						end
					end
					st_d.clen = clen_inc[CLEN_W-1:0];
					commit    = (clen_inc >= CHUNK_MAX);
				end
			end
		end

		// The final word of a sentence also closes an open field.
		if (sentence_end && st_d.found && !st_d.stop && !st_d.ended) begin
			commit = 1'b1;
		end

		// Store a finished chunk into the field it belongs to, then clear the chunk.
		if (commit && (st_d.clen != '0)) begin
			unique case (st_q.field)
				nrmc_pkg::FIELD_STATUS: st_d.status = (st_d.cfirst == nrmc_pkg::CH_A);
				nrmc_pkg::FIELD_LAT:    st_d.lat = '{st_d.cneg, st_d.iacc, st_d.facc};
				nrmc_pkg::FIELD_NS:     st_d.south = (st_d.cfirst == nrmc_pkg::CH_S);
				nrmc_pkg::FIELD_LON:    st_d.lon = '{st_d.cneg, st_d.iacc, st_d.facc};
				nrmc_pkg::FIELD_EW:     st_d.west = (st_d.cfirst == nrmc_pkg::CH_W);
				nrmc_pkg::FIELD_SPEED:  st_d.spd = '{st_d.cneg, st_d.iacc, st_d.facc};
				nrmc_pkg::FIELD_COURSE: st_d.crs = '{st_d.cneg, st_d.iacc, st_d.facc};
				default: ;
			endcase
			st_d.clen   = '0;
			st_d.cfirst = '0;
			st_d.cneg   = 1'b0;
			st_d.point  = 1'b0;
			st_d.iacc   = '0;
			st_d.facc   = '0;
			st_d.fpos   = '0;
		end
	end

	// Sentence result; hemisphere letters fold into the coordinate signs.
	assign lat_nz = (st_d.lat.ipart != '0) || (st_d.lat.fpart != '0);
	assign lon_nz = (st_d.lon.ipart != '0) || (st_d.lon.fpart != '0);

	always_comb begin
		res         = '0;
		res.found   = st_d.found;
		res.fix     = st_d.found && st_d.status && lat_nz && lon_nz;
		res.lat     = st_d.lat;
		res.lat.neg = st_d.lat.neg ^ st_d.south;
		res.lon     = st_d.lon;
		res.lon.neg = st_d.lon.neg ^ st_d.west;
		res.spd     = st_d.spd;
		res.crs     = st_d.crs;
	end

	// Parse state advances with each word and clears after a sentence end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (step) begin
			st_q <= sentence_end ? '0 : st_d;
		end
	end

endmodule

>>> rtl/core/nrmc_conv.sv
module nrmc_conv (
	input  logic                                clk,
	input  logic                                en,
	input  nrmc_pkg::raw_res_t                  res_in,
	output logic                                found_s7,
	output logic                                fix_s7,
	output logic signed [nrmc_pkg::LAT_W-1:0]   lat_s7,
	output logic signed [nrmc_pkg::LAT_W-1:0]   lon_s7,
	output logic signed [nrmc_pkg::SPD_W-1:0]   spd_s7,
	output logic signed [nrmc_pkg::SPD_W-1:0]   crs_s7
);

	nrmc_pkg::raw_val_t coord_in [2];
	nrmc_pkg::raw_val_t milli_in [2];
	logic signed [nrmc_pkg::LAT_W-1:0] coord_s7 [2];
	logic signed [nrmc_pkg::SPD_W-1:0] milli_s7 [2];
	logic found_s3, found_s4, found_s5, found_s6;
	logic fix_s3, fix_s4, fix_s5, fix_s6;

	assign coord_in[0] = res_in.lat;
	assign coord_in[1] = res_in.lon;
	assign milli_in[0] = res_in.spd;
	assign milli_in[1] = res_in.crs;
	assign lat_s7 = coord_s7[0];
	assign lon_s7 = coord_s7[1];
	assign spd_s7 = milli_s7[0];
	assign crs_s7 = milli_s7[1];

	// Sentence flags travel alongside the values.
	always_ff @(posedge clk) begin
		if (en) begin
			found_s3 <= res_in.found;
			fix_s3   <= res_in.fix;
			found_s4 <= found_s3;
			fix_s4   <= fix_s3;
			found_s5 <= found_s4;
			fix_s5   <= fix_s4;
			found_s6 <= found_s5;
			fix_s6   <= fix_s5;
			found_s7 <= found_s6;
			fix_s7   <= fix_s6;
		end
	end

	// DDMM.MMMMMM to 1e-7 degrees: degrees = ipart / 100, then minutes / 6 in 1e-7 units.
	for (genvar k = 0; k < 2; k++) begin : g_coord
		logic [nrmc_pkg::P100_W-1:0]   prod100;
		logic [nrmc_pkg::INT_W-1:0]    whole;
		logic [nrmc_pkg::INT_W-1:0]    rem;
		logic [nrmc_pkg::P3_W-1:0]     prod3;
		logic [nrmc_pkg::LAT_W-1:0]    mag;
		logic [nrmc_pkg::DEG_W-1:0]    deg_s3;
		logic [nrmc_pkg::INT_W-1:0]    ipart_s3;
		logic [nrmc_pkg::FRAC_W-1:0]   fpart_s3, fpart_s4;
		logic                          neg_s3, neg_s4, neg_s5, neg_s6;
		logic [nrmc_pkg::MIN_W-1:0]    min_s4;
		logic [nrmc_pkg::DEGSC_W-1:0]  degsc_s4, degsc_s5, degsc_s6;
		logic [nrmc_pkg::MINF_W-1:0]   minf_s5;
		logic [nrmc_pkg::QUOT_W-1:0]   quot_s6;

		assign prod100 = nrmc_pkg::P100_W'(coord_in[k].ipart) *
			nrmc_pkg::P100_W'(nrmc_pkg::DIV100_MUL);
		assign whole   = nrmc_pkg::INT_W'(deg_s3) * nrmc_pkg::HUNDRED;
		assign rem     = ipart_s3 - whole;
		assign prod3   = nrmc_pkg::P3_W'(minf_s5[nrmc_pkg::MINF_W-1:1]) *
			nrmc_pkg::P3_W'(nrmc_pkg::DIV3_MUL);
		assign mag     = nrmc_pkg::LAT_W'(degsc_s6) + nrmc_pkg::LAT_W'(quot_s6);

		always_ff @(posedge clk) begin
			if (en) begin
				deg_s3   <= prod100[nrmc_pkg::DIV100_SH +: nrmc_pkg::DEG_W];
				ipart_s3 <= coord_in[k].ipart;
				fpart_s3 <= coord_in[k].fpart;
				neg_s3   <= coord_in[k].neg;
				min_s4   <= rem[nrmc_pkg::MIN_W-1:0];
				degsc_s4 <= nrmc_pkg::DEGSC_W'(deg_s3) * nrmc_pkg::DEG_SCALE;
				fpart_s4 <= fpart_s3;
				neg_s4   <= neg_s3;
				minf_s5  <= nrmc_pkg::MINF_W'(min_s4) * nrmc_pkg::FRAC_SCALE +
					nrmc_pkg::MINF_W'(fpart_s4);
				degsc_s5 <= degsc_s4;
				neg_s5   <= neg_s4;
				quot_s6  <= prod3[nrmc_pkg::DIV3_SH +: nrmc_pkg::QUOT_W];
				degsc_s6 <= degsc_s5;
				neg_s6   <= neg_s5;
				coord_s7[k] <= !fix_s6 ? '0 : (neg_s6 ? -mag : mag);
			end
		end
	end

	// Speed and course to thousandths: ipart * 1000 + fpart / 1000.
	for (genvar k = 0; k < 2; k++) begin : g_milli
		logic [nrmc_pkg::P1000_W-1:0]  prod1000;
		logic [nrmc_pkg::MILLI_W-1:0]  fq_s3;
		logic [nrmc_pkg::INT_W-1:0]    ipart_s3;
		logic                          neg_s3, neg_s4, neg_s5, neg_s6;
		logic [nrmc_pkg::SPDMAG_W-1:0] mag_s4, mag_s5, mag_s6;
		logic [nrmc_pkg::SPD_W-1:0]    mag;

		assign prod1000 = nrmc_pkg::P1000_W'(milli_in[k].fpart) *
			nrmc_pkg::P1000_W'(nrmc_pkg::DIV1000_MUL);
		assign mag      = nrmc_pkg::SPD_W'(mag_s6);

		always_ff @(posedge clk) begin
			if (en) begin
				fq_s3    <= prod1000[nrmc_pkg::DIV1000_SH +: nrmc_pkg::MILLI_W];
				ipart_s3 <= milli_in[k].ipart;
				neg_s3   <= milli_in[k].neg;
				mag_s4   <= nrmc_pkg::SPDMAG_W'(ipart_s3) * nrmc_pkg::THOUSAND +
					nrmc_pkg::SPDMAG_W'(fq_s3);
				neg_s4   <= neg_s3;
				mag_s5   <= mag_s4;
				neg_s5   <= neg_s4;
				mag_s6   <= mag_s5;
				neg_s6   <= neg_s5;
				milli_s7[k] <= !fix_s6 ? '0 : (neg_s6 ? -mag : mag);
			end
		end
	end

endmodule

>>> rtl/core/nmea_rmc_field_extractor_core.sv
// RMC sentence field extractor.
// Input stream: one sentence character per word in s_axis_tdata[7:0]; s_axis_tlast marks
// the final character of a sentence. Output stream: one word per sentence, given after
// the word carrying tlast, with found flag, fix flag, latitude and longitude in 1e-7
// degrees, speed in thousandths of a knot and course in thousandths of a degree.
// Throughput: one character per clock cycle unless a tlast word waits on a stalled
// result; back-to-back sentences are fine. The result reaches m_axis through the
// sentence result register, five conversion stages and the output register.
// Reset: arst_n clears the parse state and all valid flags; the next character starts
// a new sentence search.
// Stall: while a result word waits with m_axis_tready low, the output word and the
// conversion pipeline hold.
// Characters keep being accepted until a tlast word reaches the input register; that
// word then waits, and s_axis_tready drops, until the pipeline can move again.
module nmea_rmc_field_extractor_core #(
	parameter int FIELD_BUFFER_BYTES = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,  // [7:0] char_byte
	input  logic         s_axis_tlast,  // sentence_end
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [127:0] m_axis_tdata   // [0] rmc_found, [1] fix_valid, [36:2] latitude,
	                                    // [71:37] longitude, [99:72] speed, [127:100] course
);

	logic               pipe_en;
	logic               adv_s1;
	logic               valid_s1;
	logic [7:0]         char_s1;
	logic               last_s1;
	logic               valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;
	nrmc_pkg::raw_res_t res_s1;
	nrmc_pkg::raw_res_t res_s2;
	logic               found_s7;
	logic               fix_s7;
	logic signed [nrmc_pkg::LAT_W-1:0] lat_s7;
	logic signed [nrmc_pkg::LAT_W-1:0] lon_s7;
	logic signed [nrmc_pkg::SPD_W-1:0] spd_s7;
	logic signed [nrmc_pkg::SPD_W-1:0] crs_s7;
	logic               out_valid_q;
	logic [127:0]       out_data_q;

	// Handshake: the result pipeline moves whenever the output word is free or taken.
	assign pipe_en       = !out_valid_q || m_axis_tready;
	assign adv_s1        = valid_s1 && (!last_s1 || pipe_en);
	assign s_axis_tready = !valid_s1 || adv_s1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			char_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// Character parser; its state steps once per word leaving the input register.
	nrmc_parser #(
		.FIELD_BUFFER_BYTES(FIELD_BUFFER_BYTES)
	) u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (adv_s1),
		.char_byte    (char_s1),
		.sentence_end (last_s1),
		.res          (res_s1)
	);

	// Sentence result register.
	always_ff @(posedge clk) begin
		if (pipe_en) begin
			res_s2 <= res_s1;
		end
	end

	// Unit conversion pipeline.
	nrmc_conv u_conv (
		.clk      (clk),
		.en       (pipe_en),
		.res_in   (res_s2),
		.found_s7 (found_s7),
		.fix_s7   (fix_s7),
		.lat_s7   (lat_s7),
		.lon_s7   (lon_s7),
		.spd_s7   (spd_s7),
		.crs_s7   (crs_s7)
	);

	// Valid flags following results through the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			valid_s5    <= 1'b0;
			valid_s6    <= 1'b0;
			valid_s7    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (pipe_en) begin
			valid_s2    <= adv_s1 && last_s1;
			valid_s3    <= valid_s2;
			valid_s4    <= valid_s3;
			valid_s5    <= valid_s4;
			valid_s6    <= valid_s5;
			valid_s7    <= valid_s6;
			out_valid_q <= valid_s7;
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (pipe_en) begin
			out_data_q <= {crs_s7, spd_s7, lon_s7, lat_s7, fix_s7, found_s7};
		end
	end

endmodule

>>> rtl/core/nrmc_checker.sv
`include "assert_macros.svh"

module nrmc_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [127:0] m_axis_tdata
);

	logic                              out_found;
	logic                              out_fix;
	logic signed [nrmc_pkg::SPD_W-1:0] out_speed;

	assign out_found = m_axis_tdata[0];
	assign out_fix   = m_axis_tdata[1];
	assign out_speed = $signed(m_axis_tdata[99:72]);

	// A stalled result word holds.
	`ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result word changed while stalled")

	// Input backpressure only comes from a stalled result.
	`ASSERT_SAME(a_in_stall_cause, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input stalled without output backpressure")

	// A valid fix requires the sentence name.
	`ASSERT_SAME(a_fix_needs_found, m_axis_tvalid && out_fix, out_found, "fix reported without RMC")

	// Without a fix all numeric fields are zero.
	`ASSERT_SAME(a_nofix_zero, m_axis_tvalid && !out_fix, m_axis_tdata[127:2] == '0, "nonzero values without a fix")

	// Speed stays within the saturated range.
	`ASSERT_SAME(a_speed_range, m_axis_tvalid, (out_speed <= nrmc_pkg::SPEED_LIMIT) && (out_speed >= -nrmc_pkg::SPEED_LIMIT), "speed out of range")

endmodule

bind nmea_rmc_field_extractor_core nrmc_checker u_nrmc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
